@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL. Every check is clocked by clk and off in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/lmf_pkg.sv @@
package lmf_pkg;

  localparam int MAX_SAMPLES = 1048576;
  localparam int IDX_CAP     = 65536;

  localparam int FORCE_W  = 24;
  localparam int ANGLE_W  = 16;
  localparam int CFG_W    = 16;
  localparam int MASS_W   = 32;
  localparam int COUNT_W  = 21;
  localparam int INDEX_W  = 17;
  localparam int SUM_W    = 52;
  localparam int STATUS_W = 2;
  localparam int REG_IDX_W = 2;

  localparam int MUL_W       = 32;
  localparam int MUL_CNT_W   = $clog2(MUL_W);
  localparam int DIV_W       = 60;
  localparam int DIV_SHORT_W = 32;
  localparam int DIVISOR_W   = 33;
  localparam int DIV_CNT_W   = $clog2(DIV_W);

  localparam logic signed [17:0] ANG_PI      = 18'sd25736;
  localparam logic signed [17:0] ANG_TWO_PI  = 18'sd51472;
  localparam logic        [14:0] ANG_HALF_PI = 15'd12868;
  localparam logic        [14:0] ANG_PI_U    = 15'd25736;
  localparam logic        [30:0] Q30_ONE     = 31'h4000_0000;
  localparam int HORNER_STAGES = 5;

  localparam logic [CFG_W-1:0] SKIP_RESET    = 16'd1000;
  localparam logic [CFG_W-1:0] OFFSET_RESET  = 16'd4342;
  localparam logic [CFG_W-1:0] GRAVITY_RESET = 16'd40182;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_SKIP    = 2'd0,
    REG_OFFSET  = 2'd1,
    REG_GRAVITY = 2'd2
  } reg_idx_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_SAT   = 2'd2
  } status_t;

  typedef struct packed {
    logic start;
    logic short_op;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  // Divisors of the Taylor series, innermost term first.
  function automatic logic [DIVISOR_W-1:0] horner_div(input logic [2:0] stage);
    logic [DIVISOR_W-1:0] k;
    case (stage)
      3'd0:    k = 33'd90;
      3'd1:    k = 33'd56;
      3'd2:    k = 33'd30;
      3'd3:    k = 33'd12;
      default: k = 33'd2;
    endcase
    return k;
  endfunction

endpackage

@@ rtl/lmf_in_if.sv @@
interface lmf_in_if import lmf_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [FORCE_W-1:0] force_req;
  logic signed [ANGLE_W-1:0] angle;
  logic                      is_last;
  modport source(output valid, force_req, angle, is_last, input ready);
  modport sink(input valid, force_req, angle, is_last, output ready);
endinterface

@@ rtl/lmf_out_if.sv @@
interface lmf_out_if import lmf_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [MASS_W-1:0] mass_estimate;
  logic [COUNT_W-1:0]       samples_used;
  logic [STATUS_W-1:0]      status;
  modport source(output valid, mass_estimate, samples_used, status, input ready);
  modport sink(input valid, mass_estimate, samples_used, status, output ready);
endinterface

@@ rtl/lmf_cfg_if.sv @@
interface lmf_cfg_if import lmf_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [REG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

@@ rtl/lmf_serial_mul.sv @@
module lmf_serial_mul import lmf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [MUL_W-1:0]     op_a,
  input  logic [MUL_W-1:0]     op_b,
  output logic [2*MUL_W-1:0]   prod,
  output unit_stat_t           stat
);

  logic [MUL_CNT_W-1:0] cnt;
  logic [MUL_W-1:0]     mcand;
  logic [MUL_W:0]       upper_sum;

  // One multiplier bit per cycle: add into the upper half, then shift right.
  assign upper_sum = {1'b0, prod[2*MUL_W-1:MUL_W]} + (prod[0] ? {1'b0, mcand} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= stat.busy && !start && (cnt == MUL_CNT_W'(MUL_W - 1));
      if (start) begin
        stat.busy <= 1'b1;
        cnt       <= '0;
      end else if (stat.busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == MUL_CNT_W'(MUL_W - 1)) begin
          stat.busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand <= op_a;
      prod  <= {{MUL_W{1'b0}}, op_b};
    end else if (stat.busy) begin
      prod <= {upper_sum, prod[MUL_W-1:1]};
    end
  end

endmodule

@@ rtl/lmf_serial_div.sv @@
module lmf_serial_div import lmf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  div_req_t             req,
  input  logic [DIV_W-1:0]     dividend,
  input  logic [DIVISOR_W-1:0] divisor,
  output logic [DIV_W-1:0]     quo,
  output unit_stat_t           stat
);

  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_CNT_W-1:0] last_cnt;
  logic [DIVISOR_W-1:0] dsr;
  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W+1:0] trial;

  // Restoring division, one quotient bit per cycle. A short run handles a
  // dividend of DIV_SHORT_W bits that has been moved to the top of the word.
  assign trial = {1'b0, rem, quo[DIV_W-1]} - {2'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= stat.busy && !req.start && (cnt == last_cnt);
      if (req.start) begin
        stat.busy <= 1'b1;
        cnt       <= '0;
        last_cnt  <= req.short_op ? DIV_CNT_W'(DIV_SHORT_W - 1) : DIV_CNT_W'(DIV_W - 1);
      end else if (stat.busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == last_cnt) begin
          stat.busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dsr <= divisor;
      rem <= '0;
      quo <= req.short_op ? (dividend << (DIV_W - DIV_SHORT_W)) : dividend;
    end else if (stat.busy) begin
      if (trial[DIVISOR_W+1]) begin
        rem <= {rem[DIVISOR_W-2:0], quo[DIV_W-1]};
        quo <= {quo[DIV_W-2:0], 1'b0};
      end else begin
        rem <= trial[DIVISOR_W-1:0];
        quo <= {quo[DIV_W-2:0], 1'b1};
      end
    end
  end

endmodule

@@ rtl/limb_mass_from_force_angle_unit.sv @@
// A skipped sample goes from acceptance straight to the finish step. A summed sample runs five
// series stages, each a multiply and a divide, then a gravity product and a mass division
// (left out when the denominator is zero), one bit a cycle in each serial unit.
// A sample marked last adds a mean division when any sample was summed, then the output register.
// One sample is in work at a time; the serial multiplier and divider set the rate.
// Reset (rst, synchronous) restores the register defaults and clears the run state.
`include "assert_macros.svh"

module limb_mass_from_force_angle_unit import lmf_pkg::*; (
  input logic         clk,
  input logic         rst,
  lmf_cfg_if.sink     cfg,
  lmf_in_if.sink      sample_ch,
  lmf_out_if.source   mass_ch
);

  typedef enum logic [9:0] {
    S_IDLE    = 10'b0000000001,
    S_HMUL_GO = 10'b0000000010,
    S_HMUL    = 10'b0000000100,
    S_HDIV    = 10'b0000001000,
    S_GMUL_GO = 10'b0000010000,
    S_GMUL    = 10'b0000100000,
    S_MDIV    = 10'b0001000000,
    S_ACC     = 10'b0010000000,
    S_FIN     = 10'b0100000000,
    S_AVG     = 10'b1000000000
  } state_t;

  state_t state;
  logic   emit_pend;
  logic   emit_go;

  logic signed [MASS_W-1:0] res_mass;
  logic [COUNT_W-1:0]       res_used;
  logic [STATUS_W-1:0]      res_status;

  logic [CFG_W-1:0]        skip_count;
  logic signed [CFG_W-1:0] angle_offset;
  logic [CFG_W-1:0]        gravity;

  logic [INDEX_W-1:0]      sample_index;
  logic [COUNT_W-1:0]      used_count;
  logic signed [SUM_W-1:0] mass_sum;
  logic                    sat_flag;

  logic signed [FORCE_W-1:0] force_r;
  logic                      last_r;
  logic [MUL_W-1:0]          x2;
  logic [30:0]               t_r;
  logic [2:0]                stage;
  logic                      cos_neg;
  logic [16:0]               c16;
  logic signed [MASS_W-1:0]  mass_r;
  logic                      sample_sat;
  logic                      sum_neg;

  logic in_acc;
  logic use_sample;
  logic signed [17:0] s_sum;
  logic signed [17:0] s_wr;
  logic [17:0]        s_abs;
  logic [14:0]        a_f;
  logic               fold_neg;
  logic [27:0]        a_sq;

  logic               mul_start;
  logic [MUL_W-1:0]   mul_a;
  logic [MUL_W-1:0]   mul_b;
  logic [2*MUL_W-1:0] mul_prod;
  unit_stat_t         mul_stat;

  div_req_t             div_req;
  logic [DIV_W-1:0]     div_dividend;
  logic [DIVISOR_W-1:0] div_divisor;
  logic [DIV_W-1:0]     div_quo;
  unit_stat_t           div_stat;

  logic [33:0]        r_diff;
  logic [30:0]        t_new;
  logic [30:0]        t_round;
  logic [24:0]        fmag;
  logic               n_pos;
  logic               n_neg;
  logic               q_neg;
  logic               den_zero;
  logic [SUM_W-1:0]   sum_mag;
  logic [MASS_W-1:0]  q_low_neg;

  assign cfg.ready       = 1'b1;
  assign sample_ch.ready = (state == S_IDLE) && !emit_pend;
  assign in_acc          = sample_ch.valid && sample_ch.ready;
  assign emit_go         = (state == S_IDLE) && emit_pend && (!mass_ch.valid || mass_ch.ready);

  assign use_sample = (sample_index >= INDEX_W'(skip_count)) &&
                      (used_count < COUNT_W'(MAX_SAMPLES));

  // Bring angle plus offset into one period, then fold onto the first quadrant.
  always_comb begin
    s_sum = 18'(sample_ch.angle) + 18'(angle_offset);
    if (s_sum > ANG_PI) begin
      s_wr = s_sum - ANG_TWO_PI;
    end else if (s_sum < -ANG_PI) begin
      s_wr = s_sum + ANG_TWO_PI;
    end else begin
      s_wr = s_sum;
    end
    s_abs = s_wr[17] ? 18'(-s_wr) : 18'(s_wr);
    if (s_abs[14:0] > ANG_HALF_PI) begin
      a_f      = ANG_PI_U - s_abs[14:0];
      fold_neg = 1'b1;
    end else begin
      a_f      = s_abs[14:0];
      fold_neg = 1'b0;
    end
    a_sq = {14'b0, a_f[13:0]} * {14'b0, a_f[13:0]};
  end

  always_comb begin
    r_diff  = 34'(Q30_ONE) - {2'b0, div_quo[31:0]};
    t_new   = r_diff[33] ? '0 : r_diff[30:0];
    t_round = t_new + 31'd8192;
    fmag    = force_r[FORCE_W-1] ? 25'(-25'(force_r)) : 25'(force_r);
    n_pos   = force_r[FORCE_W-1];
    n_neg   = (force_r != '0) && !force_r[FORCE_W-1];
    q_neg   = n_neg ^ cos_neg;
    den_zero  = (mul_prod[DIVISOR_W-1:0] == '0);
    sum_mag   = mass_sum[SUM_W-1] ? SUM_W'(-mass_sum) : SUM_W'(mass_sum);
    q_low_neg = ~div_quo[MASS_W-1:0] + 1'b1;
  end

  always_comb begin
    mul_start = (state == S_HMUL_GO) || (state == S_GMUL_GO);
    if (state == S_GMUL_GO) begin
      mul_a = {16'b0, gravity};
      mul_b = {15'b0, c16};
    end else begin
      mul_a = x2;
      mul_b = {1'b0, t_r};
    end
  end

  always_comb begin
    div_req      = '0;
    div_dividend = {8'b0, sum_mag};
    div_divisor  = {12'b0, used_count};
    case (state)
      S_HMUL: begin
        div_req.start    = mul_stat.done;
        div_req.short_op = 1'b1;
        div_dividend     = {28'b0, mul_prod[61:30]};
        div_divisor      = horner_div(stage);
      end
      S_GMUL: begin
        div_req.start = mul_stat.done && !den_zero;
        div_dividend  = {fmag[23:0], 36'b0};
        div_divisor   = mul_prod[DIVISOR_W-1:0];
      end
      S_FIN: begin
        div_req.start = last_r && (used_count != '0);
      end
      default: begin
        div_req = '0;
      end
    endcase
  end

  lmf_serial_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .op_a  (mul_a),
    .op_b  (mul_b),
    .prod  (mul_prod),
    .stat  (mul_stat)
  );

  lmf_serial_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quo      (div_quo),
    .stat     (div_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      skip_count   <= SKIP_RESET;
      angle_offset <= OFFSET_RESET;
      gravity      <= GRAVITY_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_SKIP:    skip_count   <= cfg.data;
        REG_OFFSET:  angle_offset <= cfg.data;
        REG_GRAVITY: gravity      <= cfg.data;
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      emit_pend     <= 1'b0;
      sample_index  <= '0;
      used_count    <= '0;
      mass_sum      <= '0;
      sat_flag      <= 1'b0;
      mass_ch.valid <= 1'b0;
    end else begin
      if (emit_go) begin
        mass_ch.valid <= 1'b1;
      end else if (mass_ch.ready) begin
        mass_ch.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (emit_pend) begin
            // A finished result waits here until the output register frees up.
            if (emit_go) begin
              mass_ch.mass_estimate <= res_mass;
              mass_ch.samples_used  <= res_used;
              mass_ch.status        <= res_status;
              emit_pend             <= 1'b0;
              sample_index          <= '0;
              used_count            <= '0;
              mass_sum              <= '0;
              sat_flag              <= 1'b0;
            end
          end else if (in_acc) begin
            force_r <= sample_ch.force_req;
            last_r  <= sample_ch.is_last;
            x2      <= {a_sq, 4'b0};
            cos_neg <= fold_neg;
            t_r     <= Q30_ONE;
            stage   <= '0;
            if (sample_index < INDEX_W'(IDX_CAP)) begin
              sample_index <= sample_index + 1'b1;
            end
            state <= use_sample ? S_HMUL_GO : S_FIN;
          end
        end
        S_HMUL_GO: state <= S_HMUL;
        S_HMUL: begin
          if (mul_stat.done) begin
            state <= S_HDIV;
          end
        end
        S_HDIV: begin
          if (div_stat.done) begin
            t_r <= t_new;
            if (stage == 3'(HORNER_STAGES - 1)) begin
              c16   <= t_round[30:14];
              state <= S_GMUL_GO;
            end else begin
              stage <= stage + 1'b1;
              state <= S_HMUL_GO;
            end
          end
        end
        S_GMUL_GO: state <= S_GMUL;
        S_GMUL: begin
          if (mul_stat.done) begin
            if (den_zero) begin
              sample_sat <= 1'b1;
              mass_r     <= n_pos ? 32'sh7FFF_FFFF : (n_neg ? 32'sh8000_0000 : '0);
              state      <= S_ACC;
            end else begin
              state <= S_MDIV;
            end
          end
        end
        S_MDIV: begin
          if (div_stat.done) begin
            if (q_neg) begin
              sample_sat <= (div_quo > DIV_W'(33'h0_8000_0000));
              mass_r     <= (div_quo > DIV_W'(33'h0_8000_0000)) ? 32'sh8000_0000
                                                               : q_low_neg;
            end else begin
              sample_sat <= (div_quo > DIV_W'(33'h0_7FFF_FFFF));
              mass_r     <= (div_quo > DIV_W'(33'h0_7FFF_FFFF)) ? 32'sh7FFF_FFFF
                                                               : div_quo[MASS_W-1:0];
            end
            state <= S_ACC;
          end
        end
        S_ACC: begin
          mass_sum   <= mass_sum + SUM_W'(mass_r);
          used_count <= used_count + 1'b1;
          sat_flag   <= sat_flag | sample_sat;
          state      <= S_FIN;
        end
        S_FIN: begin
          if (!last_r) begin
            state <= S_IDLE;
          end else if (used_count == '0) begin
            res_mass   <= '0;
            res_used   <= used_count;
            res_status <= STATUS_EMPTY;
            emit_pend  <= 1'b1;
            state      <= S_IDLE;
          end else begin
            sum_neg <= mass_sum[SUM_W-1];
            state   <= S_AVG;
          end
        end
        S_AVG: begin
          if (div_stat.done) begin
            res_mass   <= sum_neg ? q_low_neg : div_quo[MASS_W-1:0];
            res_used   <= used_count;
            res_status <= sat_flag ? STATUS_SAT : STATUS_OK;
            emit_pend  <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_units_exclusive, mul_stat.busy, !div_stat.busy)
  `ASSERT_NEXT(a_accept_path, in_acc, (state == S_HMUL_GO) || (state == S_FIN))
  `ASSERT_NEXT(a_emit_clears, emit_go, mass_ch.valid && (used_count == '0) && !sat_flag)

endmodule

@@ dv/lmf_mass_checker.sv @@
module lmf_mass_checker import lmf_pkg::*; (
  input  logic clk,
  input  logic rst,
  lmf_cfg_if   cfg,
  lmf_in_if    sample_ch,
  lmf_out_if   mass_ch,
  output int   errors,
  output int   pending
);

  typedef struct {
    logic signed [MASS_W-1:0] mass;
    logic [COUNT_W-1:0]       used;
    logic [STATUS_W-1:0]      status;
  } mass_result_t;

  mass_result_t means_due[$];

  logic [CFG_W-1:0]        skip_q;
  logic signed [CFG_W-1:0] offset_q;
  logic [CFG_W-1:0]        gravity_q;
  int                      seen_cnt;
  int                      used_cnt;
  longint                  mass_acc;
  bit                      clipped;

  assign pending = means_due.size();

  // Q16 cosine of a Q3.13 angle through a truncating Horner series.
  function automatic longint cosine_q16(longint s);
    longint            a;
    longint            t;
    longint            c;
    bit                neg;
    longint unsigned   x30;
    longint unsigned   x2;
    longint unsigned   p;
    int                divs[5] = '{90, 56, 30, 12, 2};
    neg = 0;
    while (s > longint'(ANG_PI)) s -= longint'(ANG_TWO_PI);
    while (s < -longint'(ANG_PI)) s += longint'(ANG_TWO_PI);
    a = (s < 0) ? -s : s;
    if (a > longint'(ANG_HALF_PI)) begin
      a = longint'(ANG_PI) - a;
      neg = 1;
    end
    x30 = longint'(a) << 17;
    x2 = (x30 * x30) >> 30;
    t = 64'sd1 << 30;
    for (int i = 0; i < 5; i++) begin
      p = (x2 * longint'(t)) >> 30;
      t = (64'sd1 << 30) - longint'(p) / divs[i];
      if (t < 0) t = 0;
    end
    c = (t + 8192) >>> 14;
    return neg ? -c : c;
  endfunction

  function automatic longint sample_mass(longint frc, longint ang);
    longint n;
    longint den;
    longint q;
    n = -frc;
    den = longint'(gravity_q) * cosine_q16(ang + longint'(offset_q));
    if (den == 0) begin
      clipped = 1;
      return (n > 0) ? 64'sd2147483647 : ((n < 0) ? -64'sd2147483648 : 0);
    end
    q = (n * (64'sd1 <<< 36)) / den;
    if (q > 64'sd2147483647) begin
      clipped = 1;
      return 64'sd2147483647;
    end
    if (q < -64'sd2147483648) begin
      clipped = 1;
      return -64'sd2147483648;
    end
    return q;
  endfunction

  always @(posedge clk) begin
    mass_result_t e;
    mass_result_t got;
    if (rst) begin
      skip_q <= SKIP_RESET;
      offset_q <= OFFSET_RESET;
      gravity_q <= GRAVITY_RESET;
      seen_cnt = 0;
      used_cnt = 0;
      mass_acc = 0;
      clipped = 0;
      errors <= 0;
      means_due.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (reg_idx_t'(cfg.index))
          REG_SKIP:    skip_q <= cfg.data;
          REG_OFFSET:  offset_q <= cfg.data;
          REG_GRAVITY: gravity_q <= cfg.data;
          default: ;
        endcase
      end
      if (sample_ch.valid && sample_ch.ready) begin
        if (seen_cnt >= int'(skip_q) && used_cnt < MAX_SAMPLES) begin
          mass_acc += sample_mass(longint'(sample_ch.force_req), longint'(sample_ch.angle));
          used_cnt++;
        end
        if (seen_cnt < IDX_CAP) seen_cnt++;
        if (sample_ch.is_last) begin
          if (used_cnt == 0) begin
            e.mass = '0;
            e.status = STATUS_EMPTY;
          end else begin
            e.mass = MASS_W'(mass_acc / longint'(used_cnt));
            e.status = clipped ? STATUS_SAT : STATUS_OK;
          end
          e.used = COUNT_W'(used_cnt);
          means_due.insert(means_due.size(), e);
          seen_cnt = 0;
          used_cnt = 0;
          mass_acc = 0;
          clipped = 0;
        end
      end
      if (mass_ch.valid && mass_ch.ready) begin
        got.mass = mass_ch.mass_estimate;
        got.used = mass_ch.samples_used;
        got.status = mass_ch.status;
        if (means_due.size() == 0) begin
          $display("%0t: unexpected beat mass=%0d used=%0d status=%0d", $time,
                   got.mass, got.used, got.status);
          errors <= errors + 1;
        end else begin
          e = means_due.pop_front();
          if (got.mass !== e.mass || got.used !== e.used || got.status !== e.status) begin
            $display("%0t: expected mass=%0d used=%0d status=%0d, got mass=%0d used=%0d status=%0d",
                     $time, e.mass, e.used, e.status, got.mass, got.used, got.status);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

@@ dv/tb_limb_mass_from_force_angle_unit.sv @@
module tb_limb_mass_from_force_angle_unit;
  import lmf_pkg::*;

  logic clk = 0;
  logic rst = 1;
  int   errors;
  int   pending;
  bit   steady = 0;
  int   sent = 0;

  lmf_cfg_if cfg ();
  lmf_in_if  sample_ch ();
  lmf_out_if mass_ch ();

  limb_mass_from_force_angle_unit DUT (
    .clk(clk), .rst(rst), .cfg(cfg), .sample_ch(sample_ch), .mass_ch(mass_ch)
  );

  lmf_mass_checker checker_i (
    .clk(clk), .rst(rst), .cfg(cfg), .sample_ch(sample_ch), .mass_ch(mass_ch),
    .errors(errors), .pending(pending)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  initial begin
    cfg.valid = 0;
    cfg.index = '0;
    cfg.data = '0;
    sample_ch.valid = 0;
    sample_ch.force_req = '0;
    sample_ch.angle = '0;
    sample_ch.is_last = 0;
    mass_ch.ready = 0;
  end

  // Result side: unless steady is set, may hold ready low for a random time before each beat.
  initial begin
    int n;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      n = steady ? 0 : $urandom_range(0, 11);
      if (n > 0) begin
        mass_ch.ready <= 0;
        repeat (n) @(posedge clk);
      end
      mass_ch.ready <= 1;
      do @(posedge clk); while (!(mass_ch.valid && mass_ch.ready));
    end
  end

  task automatic send_sample(logic signed [FORCE_W-1:0] f, logic signed [ANGLE_W-1:0] a,
                             logic last);
    int n;
    n = steady ? 0 : $urandom_range(0, 11);
    if (n > 0) begin
      sample_ch.valid <= 0;
      repeat (n) @(posedge clk);
    end
    sample_ch.valid <= 1;
    sample_ch.force_req <= f;
    sample_ch.angle <= a;
    sample_ch.is_last <= last;
    do @(posedge clk); while (!(sample_ch.valid && sample_ch.ready));
    sent++;
  endtask

  // Waits for the block to drain, including a summed sample that gives no result.
  task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] value);
    sample_ch.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (520) @(posedge clk);
    cfg.valid <= 1;
    cfg.index <= idx;
    cfg.data <= value;
    do @(posedge clk); while (!(cfg.valid && cfg.ready));
    cfg.valid <= 0;
  endtask

  function automatic logic signed [ANGLE_W-1:0] random_angle(logic signed [CFG_W-1:0] offs);
    case ($urandom_range(0, 5))
      0:       return ANGLE_W'(int'(ANG_HALF_PI) - int'(offs) + int'($urandom_range(0, 4)) - 2);
      1:       return ANGLE_W'(-int'(ANG_HALF_PI) - int'(offs));
      default: return ANGLE_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [FORCE_W-1:0] random_force();
    case ($urandom_range(0, 3))
      0:       return FORCE_W'($signed($urandom_range(0, 4000)) - 2000);
      1:       return '0;
      default: return FORCE_W'($urandom);
    endcase
  endfunction

  initial begin
    logic signed [CFG_W-1:0] offs;
    logic [CFG_W-1:0]        grav;
    int                      len;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Reset settings skip 1000 samples, so a short run reports empty.
    send_sample(24'sd5000, 16'sd0, 0);
    send_sample(-24'sd5000, 16'sd100, 1);

    write_reg(REG_SKIP, 16'd0);
    write_reg(REG_OFFSET, 16'd0);
    send_sample(24'sh7FFFFF, 16'sh7FFF, 0);
    send_sample(-24'sh800000, -16'sh8000, 0);
    send_sample(24'sd0, 16'sd0, 1);
    send_sample(-24'sd25600, 16'sd0, 1);
    // Angle at a quarter turn: cosine rounds to zero.
    send_sample(24'sd256, 16'(ANG_HALF_PI), 0);
    send_sample(-24'sd256, -16'(ANG_HALF_PI), 0);
    send_sample(24'sd0, 16'(ANG_HALF_PI), 1);
    send_sample(-24'sh800000, 16'sd12860, 1);
    send_sample(24'sd1000, 16'(ANG_PI), 1);

    write_reg(REG_GRAVITY, 16'd0);
    send_sample(24'sd300, 16'sd0, 0);
    send_sample(-24'sd300, 16'sd0, 0);
    send_sample(24'sd0, 16'sd0, 1);

    write_reg(REG_GRAVITY, 16'hFFFF);
    write_reg(REG_OFFSET, 16'sh7FFF);
    send_sample(24'sh7FFFFF, 16'sd0, 0);
    send_sample(24'sd1, -16'sh8000, 1);

    write_reg(REG_SKIP, 16'hFFFF);
    write_reg(REG_OFFSET, 16'sh8000);
    for (int i = 0; i < 4; i++) send_sample(random_force(), 16'($urandom), i == 3);

    while (sent < 560) begin
      grav = ($urandom_range(0, 7) == 0) ? 16'd1 : 16'($urandom);
      offs = ($urandom_range(0, 5) == 0) ? 16'sh7FFF : 16'($urandom);
      write_reg(REG_SKIP, 16'($urandom_range(0, 4)));
      write_reg(REG_OFFSET, offs);
      write_reg(REG_GRAVITY, grav);
      steady = ($urandom_range(0, 3) == 0);
      for (int r = 0; r < 12; r++) begin
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) send_sample(random_force(), random_angle(offs), i == len - 1);
      end
      steady = 0;
    end

    sample_ch.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #(20 * 6000000);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
